>>> hw/rtl/ycbcr_to_rgb_matrix_convert_macros.svh
// Assertion macros for the YCbCr to RGB converter.
`ifndef YCBCR_TO_RGB_MATRIX_CONVERT_MACROS_SVH
`define YCBCR_TO_RGB_MATRIX_CONVERT_MACROS_SVH

`ifndef SYNTH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define YCC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define YCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define YCC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define YCC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> hw/rtl/ycc2rgb_pkg.sv
// Shared types and constants of the YCbCr to RGB converter.
package ycc2rgb_pkg;

   localparam int PIX_W      = 8;
   localparam int COEF_W     = 16;
   localparam int FRAC_BITS  = 12;
   localparam int CSR_DATA_W = 32;
   localparam int NUM_REGS   = 6;
   localparam int NUM_CHAN   = 3;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;

   // Product of a Q3.12 gain and a 9-bit signed sample, and the wider sums.
   localparam int PROD_W = COEF_W + PIX_W + 1;
   localparam int PSUM_W = PROD_W + 1;
   localparam int ACC_W  = PROD_W + 2;

   localparam logic signed [PIX_W:0] FULL_SCALE = 9'sd255;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_RED_GAIN_Y_CB        = 3'd0,
      REG_RED_GAIN_CR_OFFSET   = 3'd1,
      REG_GREEN_GAIN_Y_CB      = 3'd2,
      REG_GREEN_GAIN_CR_OFFSET = 3'd3,
      REG_BLUE_GAIN_Y_CB       = 3'd4,
      REG_BLUE_GAIN_CR_OFFSET  = 3'd5
   } reg_index_type;

   localparam logic [CSR_DATA_W-1:0] REG_RESET [NUM_REGS] = '{
      32'h0000_12A1, 32'hF203_1989, 32'hF9BB_12A1,
      32'h0882_F2FE, 32'h2047_12A1, 32'hEEA1_0000
   };

   typedef struct packed {
      logic signed [COEF_W-1:0] offset;
      logic signed [COEF_W-1:0] gain_cr;
      logic signed [COEF_W-1:0] gain_cb;
      logic signed [COEF_W-1:0] gain_y;
   } row_type;

   typedef row_type [NUM_CHAN-1:0] matrix_type;

   // Load enables of the three arithmetic stages of a channel.
   typedef struct packed {
      logic prod_en;
      logic sum_en;
      logic out_en;
   } stage_en_type;

endpackage

>>> hw/rtl/ycc2rgb_if.sv
// Pixel stream interfaces: YCbCr beats in, RGB beats out.
interface ycc2rgb_pix_in_if;
   import ycc2rgb_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] luma;
   logic [PIX_W-1:0] chroma_blue;
   logic [PIX_W-1:0] chroma_red;
   logic             last_in;

   modport source (output valid, luma, chroma_blue, chroma_red, last_in, input ready);
   modport sink   (input valid, luma, chroma_blue, chroma_red, last_in, output ready);
endinterface

interface ycc2rgb_pix_out_if;
   import ycc2rgb_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;
   logic             last_out;

   modport source (output valid, red, green, blue, last_out, input ready);
   modport sink   (input valid, red, green, blue, last_out, output ready);
endinterface

>>> hw/rtl/ycc2rgb_csr.sv
// Register file holding the conversion matrix, written over an APB-style port.
module ycc2rgb_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [ycc2rgb_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [ycc2rgb_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [ycc2rgb_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                  pready,
   output ycc2rgb_pkg::matrix_type               matrix
);
   import ycc2rgb_pkg::*;

   logic [CSR_DATA_W-1:0] reg_ff [NUM_REGS];
   logic [REG_IDX_W-1:0]  reg_idx;
   logic                  idx_ok;
   logic                  wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[REG_IDX_W+1:2];
   assign idx_ok  = (reg_idx <= REG_BLUE_GAIN_CR_OFFSET);
   assign wr_en   = psel && penable && pwrite && idx_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            reg_ff[i] <= REG_RESET[i];
         end
      end else if (wr_en) begin
         reg_ff[reg_idx] <= pwdata;
      end
   end

   always_comb begin
      prdata = '0;
      if (idx_ok) begin
         prdata = reg_ff[reg_idx];
      end
   end

   // Each row takes its Y/Cb gains from one register and Cr gain/offset from the next.
   always_comb begin
      matrix[0] = {reg_ff[REG_RED_GAIN_CR_OFFSET], reg_ff[REG_RED_GAIN_Y_CB]};
      matrix[1] = {reg_ff[REG_GREEN_GAIN_CR_OFFSET], reg_ff[REG_GREEN_GAIN_Y_CB]};
      matrix[2] = {reg_ff[REG_BLUE_GAIN_CR_OFFSET], reg_ff[REG_BLUE_GAIN_Y_CB]};
   end

endmodule

>>> hw/rtl/ycc2rgb_chan.sv
// Datapath of one output channel: multiply, pairwise add, final add and clamp.
module ycc2rgb_chan (
   input  logic                            clock,
   input  ycc2rgb_pkg::stage_en_type       stage_en,
   input  ycc2rgb_pkg::row_type            row,
   input  logic [ycc2rgb_pkg::PIX_W-1:0]   luma,
   input  logic [ycc2rgb_pkg::PIX_W-1:0]   chroma_blue,
   input  logic [ycc2rgb_pkg::PIX_W-1:0]   chroma_red,
   output logic [ycc2rgb_pkg::PIX_W-1:0]   pix
);
   import ycc2rgb_pkg::*;

   logic signed [PROD_W-1:0] prod_y_ff, prod_cb_ff, prod_cr_ff, prod_off_ff;
   logic signed [PROD_W-1:0] prod_y_in, prod_cb_in, prod_cr_in, prod_off_in;
   logic signed [PSUM_W-1:0] psum_a_ff, psum_b_ff, psum_a_in, psum_b_in;
   logic signed [ACC_W-1:0]  acc;
   logic [PIX_W-1:0]         pix_ff, pix_in;

   // Samples are unsigned, so each gets a zero sign bit before the signed multiply.
   assign prod_y_in   = row.gain_y  * $signed({1'b0, luma});
   assign prod_cb_in  = row.gain_cb * $signed({1'b0, chroma_blue});
   assign prod_cr_in  = row.gain_cr * $signed({1'b0, chroma_red});
   assign prod_off_in = row.offset  * FULL_SCALE;

   assign psum_a_in = $signed({prod_y_ff[PROD_W-1], prod_y_ff})
                    + $signed({prod_cb_ff[PROD_W-1], prod_cb_ff});
   assign psum_b_in = $signed({prod_cr_ff[PROD_W-1], prod_cr_ff})
                    + $signed({prod_off_ff[PROD_W-1], prod_off_ff});

   assign acc = $signed({psum_a_ff[PSUM_W-1], psum_a_ff})
              + $signed({psum_b_ff[PSUM_W-1], psum_b_ff});

   // A nonnegative sum floored by the fraction bits exceeds full scale exactly when
   // any bit above the eight integer bits is set.
   always_comb begin
      if (acc[ACC_W-1]) begin
         pix_in = '0;
      end else if (|acc[ACC_W-2:FRAC_BITS+PIX_W]) begin
         pix_in = '1;
      end else begin
         pix_in = acc[FRAC_BITS+PIX_W-1:FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.prod_en) begin
         prod_y_ff   <= prod_y_in;
         prod_cb_ff  <= prod_cb_in;
         prod_cr_ff  <= prod_cr_in;
         prod_off_ff <= prod_off_in;
      end
      if (stage_en.sum_en) begin
         psum_a_ff <= psum_a_in;
         psum_b_ff <= psum_b_in;
      end
      if (stage_en.out_en) begin
         pix_ff <= pix_in;
      end
   end

   assign pix = pix_ff;

endmodule

>>> hw/rtl/ycbcr_to_rgb_matrix_convert.sv
// Top level of the YCbCr to RGB converter: input stage, valid pipeline, channels, registers.
//
//   channel   direction  payload                               handshake
//   req_if    in         luma, chroma_blue, chroma_red, last_in valid/ready
//   rsp_if    out        red, green, blue, last_out            valid/ready
//   csr       in/out     6 x 32-bit matrix registers           APB, pready tied high
//
// Four register stages: input capture, products, pairwise sums, final sum with clamp.
// One pixel enters per cycle while the output is not stalled; it passes each stage in order to rsp_if.
// Each stage loads when it is empty or the stage after it moves, so a stalled output
// freezes only the occupied stages and bubbles still fill behind it.
// Reset (synchronous) empties the pipeline and loads the BT.601 limited-range matrix.
`include "ycbcr_to_rgb_matrix_convert_macros.svh"

module ycbcr_to_rgb_matrix_convert (
   input  logic                                  clock,
   input  logic                                  reset,
   ycc2rgb_pix_in_if.sink                        req_if,
   ycc2rgb_pix_out_if.source                     rsp_if,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [ycc2rgb_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [ycc2rgb_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [ycc2rgb_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                  pready
);
   import ycc2rgb_pkg::*;

   localparam int STAGES = 4;

   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES-1:0] last_ff, last_in;
   logic [STAGES-1:0] adv;
   logic [PIX_W-1:0]  luma_ff, cb_ff, cr_ff;
   logic [PIX_W-1:0]  pix [NUM_CHAN];
   stage_en_type      stage_en;
   matrix_type        matrix;

   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || rsp_if.ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      last_in  = last_ff;
      if (adv[0]) begin
         valid_in[0] = req_if.valid;
         last_in[0]  = req_if.last_in;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (adv[k]) begin
            valid_in[k] = valid_ff[k-1];
            last_in[k]  = last_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      if (adv[0]) begin
         luma_ff <= req_if.luma;
         cb_ff   <= req_if.chroma_blue;
         cr_ff   <= req_if.chroma_red;
      end
   end

   assign stage_en.prod_en = adv[1];
   assign stage_en.sum_en  = adv[2];
   assign stage_en.out_en  = adv[3];

   ycc2rgb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .matrix  (matrix)
   );

   for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
      ycc2rgb_chan u_chan (
         .clock       (clock),
         .stage_en    (stage_en),
         .row         (matrix[c]),
         .luma        (luma_ff),
         .chroma_blue (cb_ff),
         .chroma_red  (cr_ff),
         .pix         (pix[c])
      );
   end

   assign req_if.ready    = adv[0];
   assign rsp_if.valid    = valid_ff[STAGES-1];
   assign rsp_if.red      = pix[0];
   assign rsp_if.green    = pix[1];
   assign rsp_if.blue     = pix[2];
   assign rsp_if.last_out = last_ff[STAGES-1];

   // A sink that takes beats never backs up the input side.
   `YCC_ASSERT_IMPL(a_no_stall_when_drained, clock, reset, rsp_if.ready, req_if.ready)
   // An empty capture stage always takes a beat.
   `YCC_ASSERT_IMPL(a_empty_takes, clock, reset, !valid_ff[0], req_if.ready)
   // A result held at the output with the sink stalled keeps an occupied stage just behind it occupied.
   `YCC_ASSERT_NEXT(a_hold_keeps_full, clock, reset,
      rsp_if.valid && !rsp_if.ready && valid_ff[STAGES-2], valid_ff[STAGES-2])

endmodule
